### rtl/core/fpexp_pkg.sv
package fpexp_pkg;

    localparam int ARG_W = 32;
    localparam int LIN_W = 31;
    localparam int LIM_W = 31;
    localparam int E_W   = 6;
    localparam int B_W   = 29;
    localparam int PW_W  = 26;
    localparam int T_W   = 21;
    localparam int ACC_W = 32;

    localparam int FRONT_ST  = 2;
    localparam int REDUCE_ST = 3;
    localparam int SERIES_ST = 7;
    localparam int SCALE_ST  = 5;
    localparam int NUM_ST    = FRONT_ST + REDUCE_ST + SERIES_ST + SCALE_ST;

    localparam logic [23:0] LN10_DIV20_Q27 = 24'd15452387;
    localparam logic [30:0] INV_LN2_Q30    = 31'd1549082005;
    localparam logic [31:0] LN2_Q31        = 32'd1488522236;
    localparam logic signed [ARG_W-1:0] MINUS8_Q27 = -32'sd1073741824;

    localparam logic [LIM_W-1:0] EXP_LIMIT_RST = 31'd1023359037;
    localparam logic [LIM_W-1:0] DB_LIMIT_RST  = 31'd1111097957;
    localparam logic [LIN_W-1:0] LIN_MAX       = '1;

    localparam logic CFG_EXP_LIMIT = 1'b0;
    localparam logic CFG_DB_LIMIT  = 1'b1;
    localparam logic ACT_DB        = 1'b1;

    typedef struct packed {
        logic                  sat;
        logic                  neg8;
        logic signed [E_W-1:0] e;
        logic [2:0]            idx;
    } meta_t;

    typedef struct packed {
        logic                    sat;
        logic                    neg8;
        logic signed [ARG_W-1:0] cx;
    } front_t;

    typedef struct packed {
        meta_t          m;
        logic [B_W-1:0] b;
    } reduce_t;

    typedef struct packed {
        meta_t       m;
        logic [31:0] ex_b;
    } series_t;

    // signed argument strictly above an unsigned limit
    function automatic logic above_limit(input logic signed [ARG_W-1:0] v,
                                         input logic [LIM_W-1:0] lim);
        return !v[ARG_W-1] && (v[LIM_W-1:0] > lim);
    endfunction

    function automatic logic [31:0] mul_hi(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return p[63:32];
    endfunction

    // e^(k/8) in Q1.31 for idx < 4; e^((idx-8)/8), also Q1.31, above
    function automatic logic [31:0] exp_eighth(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'd2147483648;
            3'd1:    v = 32'd2433417774;
            3'd2:    v = 32'd2757423586;
            3'd3:    v = 32'd3124570271;
            3'd4:    v = 32'd1302514674;
            3'd5:    v = 32'd1475942488;
            3'd6:    v = 32'd1672461947;
            default: v = 32'd1895147668;
        endcase
        return v;
    endfunction

    // 1/3!, 1/4!, 1/5!, 1/6!
    function automatic logic [31:0] inv_fact(input logic [1:0] k);
        logic [31:0] v;
        case (k)
            2'd0:    v = 32'd715827883;
            2'd1:    v = 32'd178956971;
            2'd2:    v = 32'd35791394;
            default: v = 32'd5965232;
        endcase
        return v;
    endfunction

    // higher series terms only for larger exponents
    function automatic logic term_on(input logic signed [E_W-1:0] e, input logic [1:0] k);
        logic on;
        case (k)
            2'd0:    on = int'(e) >= -10;
            2'd1:    on = int'(e) >= -5;
            2'd2:    on = int'(e) >= 0;
            default: on = int'(e) >= 6;
        endcase
        return on;
    endfunction

endpackage

### rtl/core/fpexp_front.sv
module fpexp_front
    import fpexp_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic                    action,
    input  logic signed [ARG_W-1:0] arg_value,
    input  logic [LIM_W-1:0]        exp_arg_limit,
    input  logic [LIM_W-1:0]        db_arg_limit,
    output front_t                  fr
);

    logic                    act_reg, act_next;
    logic                    dbsat_reg, dbsat_next;
    logic signed [ARG_W-1:0] x_reg, x_next;
    logic signed [56:0]      pd_full;
    logic [55:0]             pd_reg, pd_next;

    logic signed [ARG_W-1:0] arg;
    front_t                  fr_reg, fr_next;

    // stage 1: dB scaling by ln(10)/20
    assign pd_full = arg_value * $signed({1'b0, LN10_DIV20_Q27});

    always_comb
    begin
        act_next   = action;
        x_next     = arg_value;
        pd_next    = pd_full[55:0];
        dbsat_next = (action == ACT_DB) && above_limit(arg_value, db_arg_limit);
    end

    // stage 2: round to Q5.27, limit check, range select
    always_comb
    begin
        if (act_reg == ACT_DB)
            arg = $signed(pd_reg[55:24] + {31'd0, pd_reg[23]});
        else
            arg = x_reg;
        fr_next.sat  = dbsat_reg || above_limit(arg, exp_arg_limit);
        fr_next.neg8 = arg < MINUS8_Q27;
        if (fr_next.neg8)
            fr_next.cx = arg;
        else if (!arg[ARG_W-1] && arg[ARG_W-2])
            fr_next.cx = 32'sh7FFFFFFF;
        else
            fr_next.cx = {arg[ARG_W-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act_reg   <= act_next;
            x_reg     <= x_next;
            pd_reg    <= pd_next;
            dbsat_reg <= dbsat_next;
            fr_reg    <= fr_next;
        end
    end

    assign fr = fr_reg;

endmodule

### rtl/core/fpexp_reduce.sv
module fpexp_reduce
    import fpexp_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  front_t  fr,
    output reduce_t rd
);

    // stage 3: x / ln2
    logic signed [62:0]      p1_reg, p1_next;
    logic signed [ARG_W-1:0] cx3_reg, cx4_reg;
    logic                    sat3_reg, neg3_reg, sat4_reg, neg4_reg;

    // stage 4: nearest power of two
    logic signed [30:0]      xr;
    logic signed [E_W-1:0]   e_reg, e_next;

    // stage 5: remainder, table index and fraction
    logic signed [38:0]      em;
    logic [31:0]             y;
    reduce_t                 rd_reg, rd_next;

    assign p1_next = fr.cx * $signed({1'b0, INV_LN2_Q30});

    always_comb
    begin
        xr     = p1_reg[62:32] + {30'd0, p1_reg[31]};
        e_next = E_W'($signed(xr[30:26])) + E_W'(xr[25]);
    end

    assign em = e_reg * $signed({1'b0, LN2_Q31});

    always_comb
    begin
        y               = {cx4_reg[28:0], 3'b000} - em[31:0];
        rd_next.m.sat   = sat4_reg;
        rd_next.m.neg8  = neg4_reg;
        rd_next.m.e     = e_reg;
        rd_next.m.idx   = y[30:28];
        rd_next.b       = {y[27:0], 1'b0} | B_W'(4);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= p1_next;
            cx3_reg  <= fr.cx;
            sat3_reg <= fr.sat;
            neg3_reg <= fr.neg8;
            e_reg    <= e_next;
            cx4_reg  <= cx3_reg;
            sat4_reg <= sat3_reg;
            neg4_reg <= neg3_reg;
            rd_reg   <= rd_next;
        end
    end

    assign rd = rd_reg;

endmodule

### rtl/core/fpexp_series.sv
module fpexp_series
    import fpexp_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  reduce_t rd,
    output series_t sr
);

    // one power of b per stage, each term weighted one stage later
    meta_t          meta_reg [0:5];
    meta_t          meta_next [0:5];
    logic [B_W-1:0] b_reg [0:3];
    logic [B_W-1:0] b_next [0:3];
    logic [PW_W-1:0] pw_reg [0:4];
    logic [PW_W-1:0] pw_next [0:4];
    logic [ACC_W-1:0] acc_reg [1:5];
    logic [ACC_W-1:0] acc_next [1:5];
    logic [T_W-1:0] t_reg [2:5];
    logic [T_W-1:0] t_next [2:5];
    logic [ACC_W-1:0] sum;
    series_t        sr_reg, sr_next;

    always_comb
    begin
        meta_next[0] = rd.m;
        for (int j = 1; j <= 5; j++)
            meta_next[j] = meta_reg[j-1];

        b_next[0] = rd.b;
        for (int j = 1; j <= 3; j++)
            b_next[j] = b_reg[j-1];

        pw_next[0] = PW_W'(mul_hi(32'(rd.b), 32'(rd.b)));
        for (int j = 1; j <= 4; j++)
            pw_next[j] = PW_W'(mul_hi(32'(b_reg[j-1]), 32'(pw_reg[j-1])));

        for (int j = 2; j <= 5; j++)
            t_next[j] = T_W'(mul_hi(32'(pw_reg[j-1]), inv_fact(2'(j-2))));

        acc_next[1] = ACC_W'(b_reg[0]) + ACC_W'(pw_reg[0] >> 1);
        acc_next[2] = acc_reg[1];
        for (int j = 3; j <= 5; j++)
            acc_next[j] = acc_reg[j-1]
                        + (term_on(meta_reg[j-1].e, 2'(j-3)) ? ACC_W'(t_reg[j-1]) : '0);

        sum = acc_reg[5] + (term_on(meta_reg[5].e, 2'd3) ? ACC_W'(t_reg[5]) : '0)
            + ACC_W'(1);
        sr_next.m    = meta_reg[5];
        sr_next.ex_b = {1'b1, sum[ACC_W-1:1]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j <= 5; j++)
                meta_reg[j] <= meta_next[j];
            for (int j = 0; j <= 3; j++)
                b_reg[j] <= b_next[j];
            for (int j = 0; j <= 4; j++)
                pw_reg[j] <= pw_next[j];
            for (int j = 1; j <= 5; j++)
                acc_reg[j] <= acc_next[j];
            for (int j = 2; j <= 5; j++)
                t_reg[j] <= t_next[j];
            sr_reg <= sr_next;
        end
    end

    assign sr = sr_reg;

endmodule

### rtl/core/fpexp_scale.sv
module fpexp_scale
    import fpexp_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  series_t          sr,
    output logic [LIN_W-1:0] lin
);

    // stage 13: table value times series
    logic [63:0]           prod_reg, prod_next;
    meta_t                 m13_reg;
    // stage 14: shift by the power of two
    logic [5:0]            shamt;
    logic [47:0]           sh_reg, sh_next;
    logic                  sat14_reg, neg14_reg;
    // stage 15: round
    logic [32:0]           rsum;
    logic [LIN_W-1:0]      y0_reg, y0_next;
    logic                  sat15_reg, neg15_reg;
    // stage 16: square or double
    logic [61:0]           sq_reg, sq_next;
    logic [LIN_W-1:0]      dbl_reg, dbl_next;
    logic                  sat16_reg, neg16_reg;
    // stage 17: final select
    logic [44:0]           rsq;
    logic [LIN_W-1:0]      lin_reg, lin_next;

    assign prod_next = 64'(exp_eighth(sr.m.idx)) * 64'(sr.ex_b);

    always_comb
    begin
        shamt   = 6'(6'd27 - m13_reg.e);
        sh_next = 48'(prod_reg >> shamt);
    end

    always_comb
    begin
        rsum = {1'b0, sh_reg[47:16]} + 33'(sh_reg[15]);
        if (rsum[32:31] != 2'b00)
            y0_next = LIN_MAX;
        else
            y0_next = rsum[30:0];
    end

    always_comb
    begin
        sq_next = 62'(y0_reg) * 62'(y0_reg);
        if (y0_reg[LIN_W-1])
            dbl_next = LIN_MAX;
        else
            dbl_next = {y0_reg[LIN_W-2:0], 1'b0};
    end

    always_comb
    begin
        rsq = 45'(sq_reg[61:18]) + 45'(sq_reg[17]);
        if (sat16_reg)
            lin_next = LIN_MAX;
        else if (neg16_reg)
            lin_next = (rsq[44:31] != '0) ? LIN_MAX : rsq[30:0];
        else
            lin_next = dbl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            m13_reg   <= sr.m;
            sh_reg    <= sh_next;
            sat14_reg <= m13_reg.sat;
            neg14_reg <= m13_reg.neg8;
            y0_reg    <= y0_next;
            sat15_reg <= sat14_reg;
            neg15_reg <= neg14_reg;
            sq_reg    <= sq_next;
            dbl_reg   <= dbl_next;
            sat16_reg <= sat15_reg;
            neg16_reg <= neg15_reg;
            lin_reg   <= lin_next;
        end
    end

    assign lin = lin_reg;

endmodule

### rtl/core/fixed_point_exp_and_db_to_linear.sv
// Fixed-point e^x and dB-to-linear converter.
// Input channel (in_valid/in_ready) carries one word: action selects e^x of a
// Q5.27 argument (0) or 10^(dB/20) of a Q8.24 decibel value (1) in arg_value.
// Output channel (out_valid/out_ready) returns one word per input word, the
// unsigned Q11.20 result in linear_value, saturated, in input order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0: exp_arg_limit, 1: db_arg_limit) at once; write only while idle.
// Throughput: one word per cycle unless the full output buffer stalls. Each
// result passes the 17-stage arithmetic pipeline and then a two-word output
// buffer before it is offered.
// When the receiver stalls, the buffer takes up to two results; the pipeline
// freezes only once both are held, so in_ready stays high while one waits.
// Reset clears the pipeline and the buffer, and restores both limits.
module fixed_point_exp_and_db_to_linear
    import fpexp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [LIM_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    action,
    input  logic signed [ARG_W-1:0] arg_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [LIN_W-1:0]        linear_value
);

    logic [LIM_W-1:0]  exp_limit_reg;
    logic [LIM_W-1:0]  db_limit_reg;

    logic [NUM_ST-1:0] valid_reg, valid_next;
    logic              en;
    logic              push, pop;

    logic [1:0]        cnt_reg, cnt_next, cnt_mid;
    logic [LIN_W-1:0]  slot0_reg, slot0_next;
    logic [LIN_W-1:0]  slot1_reg, slot1_next;

    front_t            fr;
    reduce_t           rd;
    series_t           sr;
    logic [LIN_W-1:0]  lin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_limit_reg <= EXP_LIMIT_RST;
            db_limit_reg  <= DB_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXP_LIMIT: exp_limit_reg <= cfg_data;
                CFG_DB_LIMIT:  db_limit_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    fpexp_front u_front (
        .clk           (clk),
        .en            (en),
        .action        (action),
        .arg_value     (arg_value),
        .exp_arg_limit (exp_limit_reg),
        .db_arg_limit  (db_limit_reg),
        .fr            (fr)
    );

    fpexp_reduce u_reduce (
        .clk (clk),
        .en  (en),
        .fr  (fr),
        .rd  (rd)
    );

    fpexp_series u_series (
        .clk (clk),
        .en  (en),
        .rd  (rd),
        .sr  (sr)
    );

    fpexp_scale u_scale (
        .clk (clk),
        .en  (en),
        .sr  (sr),
        .lin (lin)
    );

    // pipeline advances unless the output buffer is full and not drained
    assign en        = (cnt_reg != 2'd2) || out_ready;
    assign in_ready  = en;
    assign push      = valid_reg[NUM_ST-1] && en;
    assign pop       = out_valid && out_ready;
    assign valid_next = {valid_reg[NUM_ST-2:0], in_valid};

    always_comb
    begin
        cnt_mid    = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_mid    = cnt_reg - 2'd1;
        end
        cnt_next = cnt_mid;
        if (push)
        begin
            if (cnt_mid == 2'd0)
                slot0_next = lin;
            else
                slot1_next = lin;
            cnt_next = cnt_mid + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            if (en)
                valid_reg <= valid_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign out_valid    = cnt_reg != 2'd0;
    assign linear_value = slot0_reg;

endmodule

### rtl/core/fpexp_checker.sv
module fpexp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [30:0] linear_value
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(linear_value))
        else $error("stalled output word changed");

    // input is taken whenever the output side has room
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input refused with output side free");

    // no word and no back-pressure once reset has been seen
    assert property (@(posedge clk)
        !rst_n |=> !out_valid && in_ready)
        else $error("output active during reset");

    // an offered word is always fully defined
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(linear_value))
        else $error("result word unknown");

endmodule

bind fixed_point_exp_and_db_to_linear fpexp_checker u_fpexp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .linear_value (linear_value)
);
